// ===== sv/ritd_pkg.sv =====
package ritd_pkg;

	localparam int unsigned RAM_DEPTH_DEF = 128;
	localparam int unsigned DATA_W        = 8;
	localparam int unsigned ADDR_W        = 10;
	localparam int unsigned PHASE_W       = 10;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_PEEK  = 2'd2,
		MODE_WRITE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_PA_DATA  = 3'd0,
		REG_PA_DIR   = 3'd1,
		REG_PB_DATA  = 3'd2,
		REG_PB_DIR   = 3'd3,
		REG_TIMER_A  = 3'd4,
		REG_STATUS_A = 3'd5,
		REG_TIMER_B  = 3'd6,
		REG_STATUS_B = 3'd7
	} reg_sel_t;

	// prescale 1, 8, 64, 1024
	function automatic logic [PHASE_W-1:0] prescale_mask(input logic [1:0] sel);
		logic [PHASE_W-1:0] m;
		unique case (sel)
			2'd0: m = 10'd0;
			2'd1: m = 10'd7;
			2'd2: m = 10'd63;
			2'd3: m = 10'd1023;
		endcase
		return m;
	endfunction

endpackage

// ===== sv/ritd_ram.sv =====
module ritd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/ram_io_timer_device_top.sv =====
// done and the result are registered; they appear in the cycle after the accepting edge.
// Throughput: one item per cycle, busy stays low; RAM reads come from the
// registered read port of the scratch RAM, register reads from a result register.
// Reset (arst_n low, asynchronous): port latches all ones, directions, timer and
// flags zero. Scratch RAM is not cleared. The receiver cannot stall done.
module ram_io_timer_device_top
	import ritd_pkg::*;
#(
	parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_data,
	output logic              done,
	output logic [DATA_W-1:0] read_data,
	output logic [DATA_W-1:0] port_a_pins,
	output logic [DATA_W-1:0] port_b_pins
);

	localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);
	localparam int unsigned FOLD_W = 12;

	logic              accept;
	mode_t             mode_in;
	reg_sel_t          sel;
	logic              is_reg;
	logic              is_rd;
	logic [FOLD_W-1:0] fold;
	logic [RAM_AW-1:0] ram_index;
	logic [DATA_W-1:0] ram_rdata;
	logic              ram_we;
	logic              ram_re;

	logic [DATA_W-1:0]  pa_q, pa_dir_q, pb_q, pb_dir_q, count_q;
	logic [DATA_W-1:0]  pa_n, pa_dir_n, pb_n, pb_dir_n, count_n;
	logic [1:0]         pre_sel_q, pre_sel_n;
	logic [PHASE_W-1:0] phase_q, phase_n, phase_inc;
	logic               fast_q, fast_n, usl_q, usl_n, uss_q, uss_n;
	logic               dec;

	logic              done_s1;
	logic              ram_rd_s1;
	logic [DATA_W-1:0] reg_rdata_s1;
	logic [DATA_W-1:0] reg_rdata;

	assign busy    = 1'b0;
	assign accept  = start & ~busy;
	assign mode_in = mode_t'(mode);
	assign sel     = reg_sel_t'(address[2:0]);
	assign is_reg  = address[9];
	assign is_rd   = (mode_in == MODE_READ) || (mode_in == MODE_PEEK);

	// fold address bits 7..0 into the RAM depth, quotient is below 16
	always_comb begin
		fold = {4'b0, address[7:0]};
		for (int k = 3; k >= 0; k--) begin
			if (fold >= (FOLD_W'(RAM_DEPTH) << k)) begin
				fold = fold - (FOLD_W'(RAM_DEPTH) << k);
			end
		end
	end
	assign ram_index = fold[RAM_AW-1:0];

	assign ram_we = accept && !is_reg && (mode_in == MODE_WRITE);
	assign ram_re = accept && !is_reg && is_rd;

	ritd_ram #(
		.WIDTH(DATA_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_index),
		.wdata(write_data),
		.rdata(ram_rdata)
	);

	// register read value, taken before this item's own side effects
	always_comb begin
		reg_rdata = '0;
		if (is_reg && is_rd) begin
			unique case (sel)
				REG_PA_DATA:                reg_rdata = pa_q;
				REG_PA_DIR:                 reg_rdata = pa_dir_q;
				REG_PB_DATA:                reg_rdata = pb_q;
				REG_PB_DIR:                 reg_rdata = pb_dir_q;
				REG_TIMER_A, REG_TIMER_B:   reg_rdata = count_q;
				REG_STATUS_A, REG_STATUS_B: reg_rdata = {usl_q, uss_q, 6'b0};
			endcase
		end
	end

	assign phase_inc = (phase_q + PHASE_W'(1)) & prescale_mask(pre_sel_q);
	assign dec       = fast_q || (phase_inc == '0);

	always_comb begin
		pa_n      = pa_q;
		pa_dir_n  = pa_dir_q;
		pb_n      = pb_q;
		pb_dir_n  = pb_dir_q;
		count_n   = count_q;
		pre_sel_n = pre_sel_q;
		phase_n   = phase_q;
		fast_n    = fast_q;
		usl_n     = usl_q;
		uss_n     = uss_q;
		if (accept) begin
			unique case (mode_in)
				MODE_TICK: begin
					if (!fast_q) begin
						phase_n = phase_inc;
					end
					if (dec) begin
						count_n = count_q - 8'd1;
						// wrap from zero: flag underflow and count every tick
						if (count_q == '0) begin
							usl_n  = 1'b1;
							uss_n  = 1'b1;
							fast_n = 1'b1;
						end
					end
				end
				MODE_READ: begin
					if (is_reg) begin
						if (sel == REG_TIMER_A || sel == REG_TIMER_B) begin
							fast_n = 1'b0;
						end
						if (sel == REG_STATUS_A || sel == REG_STATUS_B) begin
							uss_n = 1'b0;
						end
					end
				end
				MODE_PEEK: begin
				end
				MODE_WRITE: begin
					if (is_reg) begin
						unique case (sel)
							REG_PA_DATA: pa_n = (pa_q & ~pa_dir_q) | (write_data & pa_dir_q);
							REG_PA_DIR:  pa_dir_n = write_data;
							REG_PB_DATA: pb_n = (pb_q & ~pb_dir_q) | (write_data & pb_dir_q);
							REG_PB_DIR:  pb_dir_n = write_data;
							REG_TIMER_A, REG_STATUS_A, REG_TIMER_B, REG_STATUS_B: begin
								count_n   = write_data;
								fast_n    = 1'b0;
								usl_n     = 1'b0;
								pre_sel_n = address[1:0];
								phase_n   = prescale_mask(address[1:0]);
							end
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q      <= '1;
			pa_dir_q  <= '0;
			pb_q      <= '1;
			pb_dir_q  <= '0;
			count_q   <= '0;
			pre_sel_q <= '0;
			phase_q   <= '0;
			fast_q    <= 1'b0;
			usl_q     <= 1'b0;
			uss_q     <= 1'b0;
			done_s1   <= 1'b0;
			ram_rd_s1 <= 1'b0;
		end else begin
			pa_q      <= pa_n;
			pa_dir_q  <= pa_dir_n;
			pb_q      <= pb_n;
			pb_dir_q  <= pb_dir_n;
			count_q   <= count_n;
			pre_sel_q <= pre_sel_n;
			phase_q   <= phase_n;
			fast_q    <= fast_n;
			usl_q     <= usl_n;
			uss_q     <= uss_n;
			done_s1   <= accept;
			ram_rd_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reg_rdata_s1 <= reg_rdata;
		end
	end

	assign done        = done_s1;
	assign read_data   = ram_rd_s1 ? ram_rdata : reg_rdata_s1;
	assign port_a_pins = pa_q;
	assign port_b_pins = pb_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("done missing after accepted item");

	a_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("done without accepted item");

	a_fast_implies_load_flag: assert property (@(posedge clk) disable iff (!arst_n)
		fast_q |-> usl_q)
		else $error("fast count without underflow since load");

	a_peek_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode_in == MODE_PEEK) |=> $stable(fast_q) && $stable(uss_q)
			&& $stable(count_q) && $stable(phase_q))
		else $error("peek read changed timer state");

	a_timer_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode_in == MODE_WRITE) && is_reg && address[2]
			|=> !fast_q && !usl_q && (count_q == $past(write_data)))
		else $error("timer load did not take effect");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	import ritd_pkg::*;

	localparam logic [ADDR_W-1:0] REG_SPACE = 10'h200;
	localparam int unsigned N_RANDOM = 600;

	typedef struct {
		mode_t             mode;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		int unsigned       gap;
		bit                drain;
	} bus_op_t;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] pa;
		logic [DATA_W-1:0] pb;
	} pins_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        mode;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic              done;
	logic [DATA_W-1:0] read_data;
	logic [DATA_W-1:0] port_a_pins;
	logic [DATA_W-1:0] port_b_pins;

	ram_io_timer_device_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.address(address),
		.write_data(write_data),
		.done(done),
		.read_data(read_data),
		.port_a_pins(port_a_pins),
		.port_b_pins(port_b_pins)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// device state as the predictor sees it
	logic [DATA_W-1:0]  scratch [RAM_DEPTH_DEF];
	logic [DATA_W-1:0]  pa_latch = 8'hFF;
	logic [DATA_W-1:0]  pa_dir = 8'h00;
	logic [DATA_W-1:0]  pb_latch = 8'hFF;
	logic [DATA_W-1:0]  pb_dir = 8'h00;
	logic [DATA_W-1:0]  tmr_count = 8'h00;
	logic [PHASE_W-1:0] pre_mask = '0;
	logic [PHASE_W-1:0] pre_phase = '0;
	bit                 fast_mode = 1'b0;
	bit                 uf_load = 1'b0;
	bit                 uf_status = 1'b0;

	bus_op_t     stim_q [$];
	pins_t       want_q [$];
	bus_op_t     cur;
	bit          staged = 1'b0;
	int unsigned hold = 0;
	bit          last_accept = 1'b0;
	int unsigned n_ops = 0;
	int unsigned n_taken = 0;
	int unsigned bad_count = 0;

	// generator bookkeeping: only RAM entries already written may be read
	bit          ram_filled [RAM_DEPTH_DEF];
	int unsigned filled_idx [$];
	bit          calm = 1'b0;

	task automatic apply_op(input bus_op_t op, output pins_t r);
		reg_sel_t    sel;
		bit          dec;
		int unsigned idx;
		bit          peek;
		sel = reg_sel_t'(op.addr[2:0]);
		idx = op.addr[7:0] % RAM_DEPTH_DEF;
		peek = (op.mode == MODE_PEEK);
		r.rd = '0;
		case (op.mode)
			MODE_TICK: begin
				if (fast_mode) begin
					dec = 1'b1;
				end else begin
					pre_phase = (pre_phase + 1'b1) & pre_mask;
					dec = (pre_phase == '0);
				end
				if (dec) begin
					tmr_count = tmr_count - 1'b1;
					if (tmr_count == 8'hFF) begin
						uf_load = 1'b1;
						uf_status = 1'b1;
						fast_mode = 1'b1;
					end
				end
			end
			MODE_WRITE: begin
				if (!op.addr[9]) begin
					scratch[idx] = op.data;
				end else begin
					case (sel)
						REG_PA_DATA: pa_latch = (pa_latch & ~pa_dir) | (op.data & pa_dir);
						REG_PA_DIR:  pa_dir = op.data;
						REG_PB_DATA: pb_latch = (pb_latch & ~pb_dir) | (op.data & pb_dir);
						REG_PB_DIR:  pb_dir = op.data;
						default: begin
							// the low two select bits pick the prescale: 1, 8, 64, 1024
							case (sel)
								REG_TIMER_A:  pre_mask = 10'd0;
								REG_STATUS_A: pre_mask = 10'd7;
								REG_TIMER_B:  pre_mask = 10'd63;
								default:      pre_mask = 10'd1023;
							endcase
							pre_phase = pre_mask;
							tmr_count = op.data;
							fast_mode = 1'b0;
							uf_load = 1'b0;
						end
					endcase
				end
			end
			default: begin
				if (!op.addr[9]) begin
					r.rd = scratch[idx];
				end else begin
					case (sel)
						REG_PA_DATA: r.rd = pa_latch;
						REG_PA_DIR:  r.rd = pa_dir;
						REG_PB_DATA: r.rd = pb_latch;
						REG_PB_DIR:  r.rd = pb_dir;
						REG_TIMER_A, REG_TIMER_B: begin
							r.rd = tmr_count;
							if (!peek)
								fast_mode = 1'b0;
						end
						default: begin
							r.rd = {uf_load, uf_status, 6'b0};
							if (!peek)
								uf_status = 1'b0;
						end
					endcase
				end
			end
		endcase
		r.pa = pa_latch;
		r.pb = pb_latch;
	endtask

	function automatic logic [ADDR_W-1:0] reg_addr(reg_sel_t s);
		return REG_SPACE | 10'(($urandom_range(0, 63) << 3)) | 10'(s);
	endfunction

	function automatic logic [ADDR_W-1:0] ram_addr(int unsigned idx);
		return 10'(($urandom_range(0, 3) << 7) | idx);
	endfunction

	task automatic push_op(input mode_t m, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d, input bit drain);
		bus_op_t     op;
		int unsigned idx;
		op.mode = m;
		op.addr = a;
		op.data = d;
		op.gap = calm ? 0 : $urandom_range(0, 4);
		op.drain = drain || ($urandom_range(0, 63) == 0);
		if (m == MODE_WRITE && !a[9]) begin
			idx = a[7:0] % RAM_DEPTH_DEF;
			if (!ram_filled[idx]) begin
				ram_filled[idx] = 1'b1;
				filled_idx.push_back(idx);
			end
		end
		stim_q.push_back(op);
		n_ops++;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_TICK;
			address <= '0;
			write_data <= '0;
		end else if (!start || last_accept) begin
			if (!staged && stim_q.size() != 0) begin
				cur = stim_q.pop_front();
				staged = 1'b1;
				hold = cur.gap;
			end
			if (staged && hold == 0 && !(cur.drain && want_q.size() != 0)) begin
				start <= 1'b1;
				mode <= cur.mode;
				address <= cur.addr;
				write_data <= cur.data;
				staged = 1'b0;
			end else begin
				if (hold != 0)
					hold = hold - 1;
				start <= 1'b0;
				mode <= 2'($urandom);
				address <= 10'($urandom);
				write_data <= 8'($urandom);
			end
		end
	end

	always @(posedge clk) begin
		pins_t   exp_pins;
		pins_t   got_pins;
		bus_op_t op;
		if (!arst_n) begin
			last_accept = 1'b0;
		end else begin
			if (done) begin
				got_pins = {read_data, port_a_pins, port_b_pins};
				if (want_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected result: rd=%h pa=%h pb=%h",
							read_data, port_a_pins, port_b_pins);
				end else begin
					exp_pins = want_q.pop_front();
					if (exp_pins.rd !== got_pins.rd || exp_pins.pa !== got_pins.pa ||
							exp_pins.pb !== got_pins.pb) begin
						bad_count++;
						if (bad_count <= 10)
							$display("mismatch: rd exp %h got %h, pa exp %h got %h, pb exp %h got %h",
								exp_pins.rd, got_pins.rd, exp_pins.pa, got_pins.pa,
								exp_pins.pb, got_pins.pb);
					end
				end
			end
			last_accept = start && !busy;
			if (last_accept) begin
				op.mode = mode_t'(mode);
				op.addr = address;
				op.data = write_data;
				op.gap = 0;
				op.drain = 1'b0;
				apply_op(op, exp_pins);
				want_q.push_back(exp_pins);
				n_taken++;
			end
		end
	end

	initial begin
		int unsigned target;
		int unsigned pick;
		int unsigned idx;
		reg_sel_t    sel;
		mode_t       m;
		logic [DATA_W-1:0] d;
		logic [ADDR_W-1:0] a;

		arst_n = 1'b0;

		// reset values, ignored address bits set
		push_op(MODE_PEEK, REG_SPACE | 10'h1F8 | 10'(REG_PA_DATA), 8'hFF, 1'b0);
		push_op(MODE_READ, REG_SPACE | 10'(REG_PB_DIR), 8'h00, 1'b0);
		push_op(MODE_READ, REG_SPACE | 10'(REG_STATUS_A), 8'h00, 1'b0);
		// port latches change only where the direction bit is set
		push_op(MODE_WRITE, REG_SPACE | 10'(REG_PA_DIR), 8'hF0, 1'b0);
		push_op(MODE_WRITE, REG_SPACE | 10'(REG_PA_DATA), 8'h00, 1'b0);
		push_op(MODE_WRITE, REG_SPACE | 10'h1F8 | 10'(REG_PB_DIR), 8'hFF, 1'b0);
		push_op(MODE_WRITE, REG_SPACE | 10'(REG_PB_DATA), 8'hA5, 1'b0);
		push_op(MODE_WRITE, REG_SPACE | 10'(REG_PB_DIR), 8'h00, 1'b0);
		push_op(MODE_WRITE, REG_SPACE | 10'(REG_PB_DATA), 8'h00, 1'b0);
		push_op(MODE_READ, REG_SPACE | 10'(REG_PA_DIR), 8'h00, 1'b0);
		push_op(MODE_PEEK, REG_SPACE | 10'(REG_PB_DATA), 8'h00, 1'b0);
		// RAM extremes and index folding through bits 8..7
		push_op(MODE_WRITE, 10'h000, 8'h00, 1'b0);
		push_op(MODE_WRITE, 10'h1FF, 8'hFF, 1'b0);
		push_op(MODE_READ, 10'h07F, 8'h00, 1'b0);
		push_op(MODE_PEEK, 10'h180, 8'hFF, 1'b0);
		// underflow at prescale 1, then fast count until the count is read
		push_op(MODE_WRITE, REG_SPACE | 10'(REG_TIMER_A), 8'h02, 1'b0);
		push_op(MODE_TICK, 10'h3FF, 8'hFF, 1'b0);
		push_op(MODE_TICK, 10'h000, 8'h00, 1'b0);
		push_op(MODE_TICK, 10'h3FF, 8'hFF, 1'b0);
		push_op(MODE_PEEK, REG_SPACE | 10'(REG_STATUS_B), 8'h00, 1'b0);
		push_op(MODE_PEEK, REG_SPACE | 10'(REG_TIMER_B), 8'h00, 1'b0);
		push_op(MODE_TICK, 10'h155, 8'hAA, 1'b0);
		push_op(MODE_READ, REG_SPACE | 10'(REG_STATUS_A), 8'h00, 1'b1);
		push_op(MODE_READ, REG_SPACE | 10'(REG_STATUS_B), 8'h00, 1'b0);
		push_op(MODE_READ, REG_SPACE | 10'(REG_TIMER_A), 8'h00, 1'b0);
		// prescale 1024 loaded with zero underflows on the first tick
		push_op(MODE_WRITE, REG_SPACE | 10'(REG_STATUS_B), 8'h00, 1'b0);
		push_op(MODE_TICK, 10'h2AA, 8'h55, 1'b0);
		push_op(MODE_READ, REG_SPACE | 10'(REG_TIMER_B), 8'h00, 1'b1);

		target = n_ops + N_RANDOM;
		while (n_ops < target) begin
			if ($urandom_range(0, 29) == 0)
				calm = !calm;
			pick = $urandom_range(0, 11);
			m = ($urandom_range(0, 1) != 0) ? MODE_READ : MODE_PEEK;
			case (pick)
				0, 1, 2, 3: begin
					repeat ($urandom_range(1, 12))
						push_op(MODE_TICK, 10'($urandom), 8'($urandom), 1'b0);
				end
				4: begin
					sel = reg_sel_t'($urandom_range(4, 7));
					d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
					push_op(MODE_WRITE, reg_addr(sel), d, 1'b0);
				end
				5, 6: begin
					sel = reg_sel_t'($urandom_range(4, 7));
					push_op(m, reg_addr(sel), 8'($urandom), 1'b0);
				end
				7: begin
					sel = reg_sel_t'($urandom_range(0, 7));
					push_op(m, reg_addr(sel), 8'($urandom), 1'b0);
				end
				8: begin
					sel = reg_sel_t'($urandom_range(0, 3));
					push_op(MODE_WRITE, reg_addr(sel), 8'($urandom), 1'b0);
				end
				9: begin
					push_op(MODE_WRITE, ram_addr($urandom_range(0, RAM_DEPTH_DEF - 1)),
						8'($urandom), 1'b0);
				end
				10: begin
					if (filled_idx.size() != 0) begin
						idx = filled_idx[$urandom_range(0, filled_idx.size() - 1)];
						push_op(m, ram_addr(idx), 8'($urandom), 1'b0);
					end else begin
						push_op(MODE_WRITE, ram_addr($urandom_range(0, RAM_DEPTH_DEF - 1)),
							8'($urandom), 1'b0);
					end
				end
				default: begin
					// noise: any op, but never a read of an unwritten RAM entry
					m = mode_t'($urandom_range(0, 3));
					a = 10'($urandom);
					if ((m == MODE_READ || m == MODE_PEEK) && !a[9] &&
							!ram_filled[a[7:0] % RAM_DEPTH_DEF])
						m = MODE_WRITE;
					push_op(m, a, 8'($urandom), 1'b0);
				end
			endcase
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_ops || want_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (bad_count == 0 && want_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ritd_pkg.sv
sv/ritd_ram.sv
sv/ram_io_timer_device_top.sv
verif/tb_top.sv
